### src/bmes_pkg.sv
// ----------------------------------------------------------------------------
// bmes_pkg: shared types and constants of the bicycle model Euler step core
// Holds the controller command set, fixed-point constants, register indexes
// and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package bmes_pkg;

	// Default number of CORDIC iterations.
	localparam int CORDIC_STEPS_DEF = 24;

	// Quotient bits produced by the heading-rate divider.
	localparam int DIV_BITS = 43;

	// Configuration register indexes.
	localparam logic [2:0] CFG_WHEELBASE       = 3'd0;
	localparam logic [2:0] CFG_SPEED           = 3'd1;
	localparam logic [2:0] CFG_SAMPLE_TIME     = 3'd2;
	localparam logic [2:0] CFG_INITIAL_X       = 3'd3;
	localparam logic [2:0] CFG_INITIAL_Y       = 3'd4;
	localparam logic [2:0] CFG_INITIAL_HEADING = 3'd5;

	// Configuration reset values.
	localparam logic [23:0] WHEELBASE_RST       = 24'd65536;
	localparam logic [23:0] SPEED_RST           = 24'd0;
	localparam logic [23:0] SAMPLE_TIME_RST     = 24'd16777;
	localparam logic [31:0] INITIAL_X_RST       = 32'd0;
	localparam logic [31:0] INITIAL_Y_RST       = 32'd0;
	localparam logic [31:0] INITIAL_HEADING_RST = 32'd0;

	// Angles in Q.30 radians, held in 38 bits for the heading reduction.
	localparam logic signed [37:0] ANG_PI      = 38'sd3373259426;
	localparam logic signed [37:0] ANG_HALF_PI = 38'sd1686629713;
	localparam logic signed [37:0] ANG_TWO_PI  = 38'sd6746518852;

	// Steering clamp: 90 degrees and 89 degrees in Q3.28.
	localparam logic signed [31:0] STEER_LIM = 32'sd421657428;
	localparam logic signed [31:0] STEER_SET = 32'sd416972346;

	// CORDIC start value (inverse gain) in Q.30.
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

	// Largest heading increment magnitude, 2^42.
	localparam logic [42:0] MAG_MAX = 43'd4398046511104;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_RELOAD,
		OP_LOAD,
		OP_REDUCE,
		OP_FOLD,
		OP_CINIT_H,
		OP_CINIT_S,
		OP_CSTEP,
		OP_SAVE_H,
		OP_SAVE_S,
		OP_MUL_VT,
		OP_TAKE_VT,
		OP_MUL_NUM,
		OP_MUL_DEN,
		OP_MUL_DX,
		OP_MUL_DY,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [4:0] idx;
	} cmd_t;

	typedef struct packed {
		logic reduce_done;
	} status_t;

	// Arctangent of 2^-i in Q.30.
	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		logic signed [33:0] v;
		case (i)
			5'd0:  v = 34'sd843314857;
			5'd1:  v = 34'sd497837829;
			5'd2:  v = 34'sd263043837;
			5'd3:  v = 34'sd133525159;
			5'd4:  v = 34'sd67021687;
			5'd5:  v = 34'sd33543516;
			5'd6:  v = 34'sd16775851;
			5'd7:  v = 34'sd8388437;
			5'd8:  v = 34'sd4194283;
			5'd9:  v = 34'sd2097149;
			5'd10: v = 34'sd1048576;
			5'd11: v = 34'sd524288;
			5'd12: v = 34'sd262144;
			5'd13: v = 34'sd131072;
			5'd14: v = 34'sd65536;
			5'd15: v = 34'sd32768;
			5'd16: v = 34'sd16384;
			5'd17: v = 34'sd8192;
			5'd18: v = 34'sd4096;
			5'd19: v = 34'sd2048;
			5'd20: v = 34'sd1024;
			5'd21: v = 34'sd512;
			5'd22: v = 34'sd256;
			5'd23: v = 34'sd128;
			5'd24: v = 34'sd64;
			5'd25: v = 34'sd32;
			5'd26: v = 34'sd16;
			5'd27: v = 34'sd8;
			5'd28: v = 34'sd4;
			5'd29: v = 34'sd2;
			5'd30: v = 34'sd1;
			default: v = 34'sd0;
		endcase
		return v;
	endfunction

endpackage

### src/bmes_ctrl.sv
// ----------------------------------------------------------------------------
// bmes_ctrl: step sequencer of the bicycle model Euler step core
// Walks one item through reduction, two CORDIC runs, the multiplies and the
// divider, and owns the result valid flag.
// ----------------------------------------------------------------------------
module bmes_ctrl #(
	parameter int CORDIC_STEPS = bmes_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic               wb_zero,
	output logic               out_valid,
	input  logic               out_ready,
	input  bmes_pkg::status_t  status,
	output bmes_pkg::cmd_t     cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_REDUCE, S_FOLD, S_CINIT_H, S_CSTEP_H, S_SAVE_H,
		S_CINIT_S, S_CSTEP_S, S_SAVE_S, S_MUL_VT, S_TAKE_VT, S_MUL_NUM,
		S_MUL_DEN, S_MUL_DX, S_MUL_DY, S_DIV_INIT, S_DIV, S_FINISH
	} state_t;

	localparam logic [5:0] CordicLast = 6'(CORDIC_STEPS - 1);
	localparam logic [5:0] DivLast    = 6'(bmes_pkg::DIV_BITS - 1);

	state_t     state_q;
	logic [5:0] cnt_q;
	logic       out_valid_q;
	logic       accept;
	logic       finish;

	// Handshake decisions.
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign finish    = (state_q == S_FINISH) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// Command to the datapath for the current state.
	always_comb begin
		cmd.idx = cnt_q[4:0];
		unique case (state_q)
			S_IDLE: begin
				if (!accept) cmd.op = bmes_pkg::OP_NONE;
				else if (mode) cmd.op = bmes_pkg::OP_RELOAD;
				else if (wb_zero) cmd.op = bmes_pkg::OP_NONE;
				else cmd.op = bmes_pkg::OP_LOAD;
			end
			S_REDUCE:   cmd.op = bmes_pkg::OP_REDUCE;
			S_FOLD:     cmd.op = bmes_pkg::OP_FOLD;
			S_CINIT_H:  cmd.op = bmes_pkg::OP_CINIT_H;
			S_CSTEP_H:  cmd.op = bmes_pkg::OP_CSTEP;
			S_SAVE_H:   cmd.op = bmes_pkg::OP_SAVE_H;
			S_CINIT_S:  cmd.op = bmes_pkg::OP_CINIT_S;
			S_CSTEP_S:  cmd.op = bmes_pkg::OP_CSTEP;
			S_SAVE_S:   cmd.op = bmes_pkg::OP_SAVE_S;
			S_MUL_VT:   cmd.op = bmes_pkg::OP_MUL_VT;
			S_TAKE_VT:  cmd.op = bmes_pkg::OP_TAKE_VT;
			S_MUL_NUM:  cmd.op = bmes_pkg::OP_MUL_NUM;
			S_MUL_DEN:  cmd.op = bmes_pkg::OP_MUL_DEN;
			S_MUL_DX:   cmd.op = bmes_pkg::OP_MUL_DX;
			S_MUL_DY:   cmd.op = bmes_pkg::OP_MUL_DY;
			S_DIV_INIT: cmd.op = bmes_pkg::OP_DIV_INIT;
			S_DIV:      cmd.op = bmes_pkg::OP_DIV_STEP;
			S_FINISH:   cmd.op = finish ? bmes_pkg::OP_FINISH : bmes_pkg::OP_NONE;
			default:    cmd.op = bmes_pkg::OP_NONE;
		endcase
	end

	// State, iteration counter and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (finish) out_valid_q <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (accept && !mode && !wb_zero) state_q <= S_REDUCE;
				end
				S_REDUCE: begin
					if (status.reduce_done) state_q <= S_FOLD;
				end
				S_FOLD: state_q <= S_CINIT_H;
				S_CINIT_H: begin
					cnt_q   <= '0;
					state_q <= S_CSTEP_H;
				end
				S_CSTEP_H: begin
					if (cnt_q == CordicLast) begin
						cnt_q   <= '0;
						state_q <= S_SAVE_H;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_SAVE_H: state_q <= S_CINIT_S;
				S_CINIT_S: begin
					cnt_q   <= '0;
					state_q <= S_CSTEP_S;
				end
				S_CSTEP_S: begin
					if (cnt_q == CordicLast) begin
						cnt_q   <= '0;
						state_q <= S_SAVE_S;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_SAVE_S:   state_q <= S_MUL_VT;
				S_MUL_VT:   state_q <= S_TAKE_VT;
				S_TAKE_VT:  state_q <= S_MUL_NUM;
				S_MUL_NUM:  state_q <= S_MUL_DEN;
				S_MUL_DEN:  state_q <= S_MUL_DX;
				S_MUL_DX:   state_q <= S_MUL_DY;
				S_MUL_DY:   state_q <= S_DIV_INIT;
				S_DIV_INIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == DivLast) begin
						cnt_q   <= '0;
						state_q <= S_FINISH;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_FINISH: begin
					if (finish) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A result is only written into a free or draining output register.
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == bmes_pkg::OP_FINISH |-> (!out_valid_q || out_ready))
		else $error("result written over a pending item");

	// An accepted Euler step starts the heading reduction.
	a_step_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !mode && !wb_zero) |=> state_q == S_REDUCE)
		else $error("accepted step did not start");

	// CORDIC iteration count stays within the configured length.
	a_cordic_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CSTEP_H || state_q == S_CSTEP_S) |-> cnt_q <= CordicLast)
		else $error("CORDIC counter overran");

	// Divider bit count stays within the quotient width.
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q <= DivLast)
		else $error("divider counter overran");

	// Finishing always raises the result valid.
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_valid_q)
		else $error("result valid not raised");

endmodule

### src/bmes_datapath.sv
// ----------------------------------------------------------------------------
// bmes_datapath: arithmetic of the bicycle model Euler step core
// Holds the pose, a shared CORDIC iteration unit, one shared multiplier, a
// radix-2 restoring divider and the result register.
// ----------------------------------------------------------------------------
module bmes_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  bmes_pkg::cmd_t      cmd,
	output bmes_pkg::status_t   status,
	input  logic signed [31:0]  steering_angle,
	input  logic [23:0]         wheelbase,
	input  logic signed [23:0]  speed,
	input  logic [23:0]         sample_time,
	input  logic signed [31:0]  initial_x,
	input  logic signed [31:0]  initial_y,
	input  logic signed [31:0]  initial_heading,
	output logic signed [31:0]  pose_x,
	output logic signed [31:0]  pose_y,
	output logic signed [31:0]  pose_heading,
	output logic                saturated
);

	// Pose state.
	logic signed [31:0] pos_x_q, pos_y_q, head_q;

	// Work registers of one item.
	logic signed [31:0] steer_q;
	logic signed [37:0] ang_q;
	logic               neg_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic signed [33:0] hc_q, hs_q, sc_q, ss_q;
	logic signed [32:0] vt_q;
	logic signed [65:0] prod_q;
	logic               num_neg_q;
	logic [62:0]        un_q;
	logic [54:0]        ud_q;
	logic signed [27:0] dx_q, dy_q;
	logic [54:0]        rem_q;
	logic [42:0]        quo_q;
	logic [42:0]        dsh_q;
	logic               dsat_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [33:0] xs, ys, at;
	logic signed [65:0] rnd_vt, rnd_d, num_abs;
	logic [55:0]        trial;
	logic               trial_ge;
	logic [42:0]        mag;
	logic signed [44:0] dhead, sum_h, sum_x, sum_y;
	logic               ovf_x, ovf_y, ovf_h;

	// Saturate a wide sum to the 32-bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
		logic signed [31:0] r;
		if (v > 45'sd2147483647) r = 32'sh7FFFFFFF;
		else if (v < -45'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	// Heading reduction status.
	assign status.reduce_done = !(ang_q >= bmes_pkg::ANG_PI) &&
		!(ang_q < -bmes_pkg::ANG_PI);

	// Shared multiplier operand selection.
	always_comb begin
		case (cmd.op)
			bmes_pkg::OP_MUL_VT: begin
				mul_a = {{9{speed[23]}}, speed};
				mul_b = {9'b0, sample_time};
			end
			bmes_pkg::OP_MUL_NUM: begin
				mul_a = vt_q;
				mul_b = ss_q[32:0];
			end
			bmes_pkg::OP_MUL_DEN: begin
				mul_a = {9'b0, wheelbase};
				mul_b = sc_q[32:0];
			end
			bmes_pkg::OP_MUL_DX: begin
				mul_a = vt_q;
				mul_b = hc_q[32:0];
			end
			bmes_pkg::OP_MUL_DY: begin
				mul_a = vt_q;
				mul_b = hs_q[32:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// CORDIC shifts and angle step.
	assign xs = cx_q >>> cmd.idx;
	assign ys = cy_q >>> cmd.idx;
	assign at = bmes_pkg::atan_q30(cmd.idx);

	// Rounding and magnitude of the product register.
	assign rnd_vt  = prod_q + 66'sd32768;
	assign rnd_d   = prod_q + 66'sd137438953472;
	assign num_abs = prod_q[65] ? -prod_q : prod_q;

	// One restoring divider step.
	assign trial    = {rem_q, dsh_q[42]};
	assign trial_ge = trial >= {1'b0, ud_q};

	// Pose updates with saturation detection.
	always_comb begin
		if (dsat_q || quo_q > bmes_pkg::MAG_MAX) mag = bmes_pkg::MAG_MAX;
		else mag = quo_q;
		dhead = num_neg_q ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
		sum_h = 45'(head_q) + dhead;
		sum_x = 45'(pos_x_q) + 45'(dx_q);
		sum_y = 45'(pos_y_q) + 45'(dy_q);
		ovf_x = (sum_x > 45'sd2147483647) || (sum_x < -45'sd2147483648);
		ovf_y = (sum_y > 45'sd2147483647) || (sum_y < -45'sd2147483648);
		ovf_h = (sum_h > 45'sd2147483647) || (sum_h < -45'sd2147483648);
	end

	// Pose registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= bmes_pkg::INITIAL_X_RST;
			pos_y_q <= bmes_pkg::INITIAL_Y_RST;
			head_q  <= bmes_pkg::INITIAL_HEADING_RST;
		end else if (cmd.op == bmes_pkg::OP_RELOAD) begin
			pos_x_q <= initial_x;
			pos_y_q <= initial_y;
			head_q  <= initial_heading;
		end else if (cmd.op == bmes_pkg::OP_FINISH) begin
			pos_x_q <= sat32(sum_x);
			pos_y_q <= sat32(sum_y);
			head_q  <= sat32(sum_h);
		end
	end

	// Work registers, one operation per cycle.
	always_ff @(posedge clk) begin
		case (cmd.op)
			bmes_pkg::OP_LOAD: begin
				if (steering_angle >= bmes_pkg::STEER_LIM) steer_q <= bmes_pkg::STEER_SET;
				else if (steering_angle <= -bmes_pkg::STEER_LIM)
					steer_q <= -bmes_pkg::STEER_SET;
				else steer_q <= steering_angle;
				ang_q <= {head_q, 6'b0};
			end
			bmes_pkg::OP_REDUCE: begin
				if (ang_q >= bmes_pkg::ANG_PI) ang_q <= ang_q - bmes_pkg::ANG_TWO_PI;
				else if (ang_q < -bmes_pkg::ANG_PI) ang_q <= ang_q + bmes_pkg::ANG_TWO_PI;
			end
			bmes_pkg::OP_FOLD: begin
				if (ang_q > bmes_pkg::ANG_HALF_PI) begin
					ang_q <= ang_q - bmes_pkg::ANG_PI;
					neg_q <= 1'b1;
				end else if (ang_q < -bmes_pkg::ANG_HALF_PI) begin
					ang_q <= ang_q + bmes_pkg::ANG_PI;
					neg_q <= 1'b1;
				end else begin
					neg_q <= 1'b0;
				end
			end
			bmes_pkg::OP_CINIT_H: begin
				cx_q <= bmes_pkg::GAIN_Q30;
				cy_q <= '0;
				cz_q <= ang_q[33:0];
			end
			bmes_pkg::OP_CINIT_S: begin
				cx_q <= bmes_pkg::GAIN_Q30;
				cy_q <= '0;
				cz_q <= {steer_q, 2'b0};
			end
			bmes_pkg::OP_CSTEP: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + at;
				end
			end
			bmes_pkg::OP_SAVE_H: begin
				hc_q <= neg_q ? -cx_q : cx_q;
				hs_q <= neg_q ? -cy_q : cy_q;
			end
			bmes_pkg::OP_SAVE_S: begin
				sc_q <= (cx_q < 34'sd1) ? 34'sd1 : cx_q;
				ss_q <= cy_q;
			end
			bmes_pkg::OP_MUL_VT: prod_q <= mul_a * mul_b;
			bmes_pkg::OP_TAKE_VT: vt_q <= rnd_vt[48:16];
			bmes_pkg::OP_MUL_NUM: prod_q <= mul_a * mul_b;
			bmes_pkg::OP_MUL_DEN: begin
				num_neg_q <= prod_q[65];
				un_q      <= num_abs[62:0];
				prod_q    <= mul_a * mul_b;
			end
			bmes_pkg::OP_MUL_DX: begin
				ud_q   <= prod_q[54:0];
				prod_q <= mul_a * mul_b;
			end
			bmes_pkg::OP_MUL_DY: begin
				dx_q   <= rnd_d[65:38];
				prod_q <= mul_a * mul_b;
			end
			bmes_pkg::OP_DIV_INIT: begin
				dy_q   <= rnd_d[65:38];
				dsat_q <= {19'b0, un_q[62:27]} >= ud_q;
				rem_q  <= {19'b0, un_q[62:27]};
				dsh_q  <= {un_q[26:0], 16'b0};
				quo_q  <= '0;
			end
			bmes_pkg::OP_DIV_STEP: begin
				rem_q <= trial_ge ? 55'(trial - {1'b0, ud_q}) : trial[54:0];
				dsh_q <= {dsh_q[41:0], 1'b0};
				quo_q <= {quo_q[41:0], trial_ge};
			end
			default: begin
			end
		endcase
	end

	// Result register: pose before the step and the saturation flag.
	always_ff @(posedge clk) begin
		if (cmd.op == bmes_pkg::OP_FINISH) begin
			pose_x       <= pos_x_q;
			pose_y       <= pos_y_q;
			pose_heading <= head_q;
			saturated    <= ovf_x || ovf_y || ovf_h;
		end
	end

endmodule

### src/bicycle_model_euler_step_core.sv
// ----------------------------------------------------------------------------
// bicycle_model_euler_step_core: kinematic bicycle model, forward Euler
// Holds the configuration registers and joins the step sequencer with the
// arithmetic datapath.
//
//   Channel   Signals                                   Direction
//   input     in_valid, in_ready, mode, steering_angle  in
//   result    out_valid, out_ready, pose_x/y/heading,   out
//             saturated
//   config    cfg_write_en, cfg_index, cfg_data         in
//
// An Euler step's time from acceptance to the result grows with the heading
// reduction and with CORDIC_STEPS; it is set by the shared CORDIC unit and
// the one-bit-per-cycle divider.
// A reload or a step with zero wheelbase is handled at acceptance and gives no result.
// A new item is taken once the previous one leaves the datapath; a result
// waiting on out_ready stalls only the final write of the following item.
// Reset clears the sequencer and the pose and sets the configuration registers to their reset values.
// ----------------------------------------------------------------------------
module bicycle_model_euler_step_core #(
	parameter int CORDIC_STEPS = bmes_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic signed [31:0] steering_angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pose_x,
	output logic signed [31:0] pose_y,
	output logic signed [31:0] pose_heading,
	output logic               saturated,
	input  logic               cfg_write_en,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic [23:0]        wheelbase_q;
	logic signed [23:0] speed_q;
	logic [23:0]        sample_time_q;
	logic signed [31:0] initial_x_q, initial_y_q, initial_heading_q;

	bmes_pkg::cmd_t    cmd;
	bmes_pkg::status_t status;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q       <= bmes_pkg::WHEELBASE_RST;
			speed_q           <= bmes_pkg::SPEED_RST;
			sample_time_q     <= bmes_pkg::SAMPLE_TIME_RST;
			initial_x_q       <= bmes_pkg::INITIAL_X_RST;
			initial_y_q       <= bmes_pkg::INITIAL_Y_RST;
			initial_heading_q <= bmes_pkg::INITIAL_HEADING_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				bmes_pkg::CFG_WHEELBASE:       wheelbase_q       <= cfg_data[23:0];
				bmes_pkg::CFG_SPEED:           speed_q           <= cfg_data[23:0];
				bmes_pkg::CFG_SAMPLE_TIME:     sample_time_q     <= cfg_data[23:0];
				bmes_pkg::CFG_INITIAL_X:       initial_x_q       <= cfg_data;
				bmes_pkg::CFG_INITIAL_Y:       initial_y_q       <= cfg_data;
				bmes_pkg::CFG_INITIAL_HEADING: initial_heading_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Step sequencer.
	bmes_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.wb_zero   (wheelbase_q == 24'd0),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Arithmetic datapath.
	bmes_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.steering_angle  (steering_angle),
		.wheelbase       (wheelbase_q),
		.speed           (speed_q),
		.sample_time     (sample_time_q),
		.initial_x       (initial_x_q),
		.initial_y       (initial_y_q),
		.initial_heading (initial_heading_q),
		.pose_x          (pose_x),
		.pose_y          (pose_y),
		.pose_heading    (pose_heading),
		.saturated       (saturated)
	);

endmodule

### sim/bmes_checker.sv
// ----------------------------------------------------------------------------
// bmes_checker: pose predictor and result checker for the Euler step core
// Watches the input, result and configuration ports, runs an integer model
// of each accepted step and compares every result item with the oldest
// predicted pose.
// ----------------------------------------------------------------------------
module bmes_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               mode,
	input  logic signed [31:0] steering_angle,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] pose_x,
	input  logic signed [31:0] pose_y,
	input  logic signed [31:0] pose_heading,
	input  logic               saturated,
	input  logic               cfg_write_en,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 fail_count,
	output int                 pending,
	output int                 results_seen,
	output int                 saturations_seen
);

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] hd;
		logic               sat;
	} pose_t;

	// Shadow configuration and pose.
	logic [23:0]        wb_q, spd_q, ts_q;
	logic signed [31:0] ix_q, iy_q, ih_q;
	longint             px, py, ph;
	pose_t              pose_fifo[$];

	assign pending = pose_fifo.size();

	function automatic longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_sh(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// Rotation-mode CORDIC on a Q.30 angle.
	function automatic void rotate(input longint z, output longint c, output longint s);
		longint cx, cy, nx;
		cx = bmes_pkg::GAIN_Q30;
		cy = 0;
		for (int i = 0; i < bmes_pkg::CORDIC_STEPS_DEF; i++) begin
			if (z >= 0) begin
				nx = cx - floor_sh(cy, i);
				cy = cy + floor_sh(cx, i);
				z -= bmes_pkg::atan_q30(i[4:0]);
			end else begin
				nx = cx + floor_sh(cy, i);
				cy = cy - floor_sh(cx, i);
				z += bmes_pkg::atan_q30(i[4:0]);
			end
			cx = nx;
		end
		c = cx;
		s = cy;
	endfunction

	function automatic longint add_clip(longint a, longint d, inout logic flag);
		longint r;
		r = a + d;
		if (r > 64'sd2147483647) begin
			flag = 1'b1;
			return 64'sd2147483647;
		end
		if (r < -64'sd2147483648) begin
			flag = 1'b1;
			return -64'sd2147483648;
		end
		return r;
	endfunction

	// Advance the pose by one step and return the pose seen before it.
	function automatic pose_t euler_step(input logic signed [31:0] steer_in);
		pose_t           p;
		longint          st, a, hc, hs, sc, ss, vt, num, dh;
		longint unsigned un, ud, q, r, mag;
		logic            neg, flag;
		neg = 1'b0;
		flag = 1'b0;
		st = steer_in;
		if (st >= bmes_pkg::STEER_LIM) st = bmes_pkg::STEER_SET;
		else if (st <= -longint'(bmes_pkg::STEER_LIM)) st = -longint'(bmes_pkg::STEER_SET);
		p.x = px[31:0];
		p.y = py[31:0];
		p.hd = ph[31:0];
		a = (ph * 64) % longint'(bmes_pkg::ANG_TWO_PI);
		if (a >= bmes_pkg::ANG_PI) a -= bmes_pkg::ANG_TWO_PI;
		else if (a < -longint'(bmes_pkg::ANG_PI)) a += bmes_pkg::ANG_TWO_PI;
		if (a > bmes_pkg::ANG_HALF_PI) begin
			a -= bmes_pkg::ANG_PI;
			neg = 1'b1;
		end else if (a < -longint'(bmes_pkg::ANG_HALF_PI)) begin
			a += bmes_pkg::ANG_PI;
			neg = 1'b1;
		end
		rotate(a, hc, hs);
		if (neg) begin
			hc = -hc;
			hs = -hs;
		end
		rotate(st * 4, sc, ss);
		if (sc < 1) sc = 1;
		vt = round_sh(longint'($signed(spd_q)) * longint'(ts_q), 16);
		num = vt * ss;
		un = num < 0 ? longint'(-num) : num;
		ud = longint'(wb_q) * sc;
		q = un / ud;
		r = un % ud;
		if (q >= (64'd1 << 26)) begin
			mag = bmes_pkg::MAG_MAX;
		end else begin
			mag = q << 16;
			for (int b = 15; b >= 0; b--) begin
				r = r << 1;
				if (r >= ud) begin
					r -= ud;
					mag |= 64'd1 << b;
				end
			end
			if (mag > bmes_pkg::MAG_MAX) mag = bmes_pkg::MAG_MAX;
		end
		dh = num < 0 ? -longint'(mag) : longint'(mag);
		px = add_clip(px, round_sh(vt * hc, 38), flag);
		py = add_clip(py, round_sh(vt * hs, 38), flag);
		ph = add_clip(ph, dh, flag);
		p.sat = flag;
		return p;
	endfunction

	// Track configuration writes and accepted items; check results.
	always @(posedge clk or negedge arst_n) begin
		pose_t p;
		if (!arst_n) begin
			wb_q <= bmes_pkg::WHEELBASE_RST;
			spd_q <= bmes_pkg::SPEED_RST;
			ts_q <= bmes_pkg::SAMPLE_TIME_RST;
			ix_q <= bmes_pkg::INITIAL_X_RST;
			iy_q <= bmes_pkg::INITIAL_Y_RST;
			ih_q <= bmes_pkg::INITIAL_HEADING_RST;
			px = 0;
			py = 0;
			ph = 0;
			pose_fifo.delete();
			fail_count <= 0;
			results_seen <= 0;
			saturations_seen <= 0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					bmes_pkg::CFG_WHEELBASE:       wb_q <= cfg_data[23:0];
					bmes_pkg::CFG_SPEED:           spd_q <= cfg_data[23:0];
					bmes_pkg::CFG_SAMPLE_TIME:     ts_q <= cfg_data[23:0];
					bmes_pkg::CFG_INITIAL_X:       ix_q <= cfg_data;
					bmes_pkg::CFG_INITIAL_Y:       iy_q <= cfg_data;
					bmes_pkg::CFG_INITIAL_HEADING: ih_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (mode) begin
					px = ix_q;
					py = iy_q;
					ph = ih_q;
				end else if (wb_q != 0) begin
					p = euler_step(steering_angle);
					pose_fifo = {pose_fifo, p};
				end
			end
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (saturated) saturations_seen <= saturations_seen + 1;
				if (pose_fifo.size() == 0) begin
					$error("result item with no step pending");
					fail_count <= fail_count + 1;
				end else begin
					p = pose_fifo.pop_front();
					if (pose_x !== p.x || pose_y !== p.y || pose_heading !== p.hd ||
							saturated !== p.sat) begin
						if (pose_x !== p.x)
							$error("pose_x expected %0d got %0d", p.x, pose_x);
						if (pose_y !== p.y)
							$error("pose_y expected %0d got %0d", p.y, pose_y);
						if (pose_heading !== p.hd)
							$error("pose_heading expected %0d got %0d", p.hd, pose_heading);
						if (saturated !== p.sat)
							$error("saturated expected %0b got %0b", p.sat, saturated);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the bicycle model Euler step core
// Drives directed and random steering items through several register
// settings with random idling on both channels; the checker judges results.
// ----------------------------------------------------------------------------
module testbench;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               mode = 1'b0;
	logic signed [31:0] steering_angle = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] pose_x, pose_y, pose_heading;
	logic               saturated;
	logic               cfg_write_en = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	int                 fail_count, pending, results_seen, saturations_seen;
	int                 send_idle_pct = 17;
	int                 recv_idle_pct = 70;
	int                 items_sent = 0;

	always #5 clk = ~clk;

	bicycle_model_euler_step_core i_dut (.*);

	bmes_checker i_checker (.*);

	// Result side stalls at random.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Valid stays high between back-to-back items and drops only on idle cycles.
	task automatic send_item(input logic m, input logic [31:0] steer);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		steering_angle <= steer;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// Stop sending and wait until every expected result has come.
	task automatic wait_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic drain_steps();
		wait_results();
		repeat (140) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	// Random steering: mostly within the clamp, sometimes anywhere.
	function automatic logic [31:0] rand_steer();
		if ($urandom_range(3) == 0) return $urandom;
		return $signed($urandom_range(843314856)) - 32'sd421657428;
	endfunction

	task automatic set_setting(input logic [23:0] wb, input logic [23:0] spd,
			input logic [23:0] ts, input logic [31:0] x0, input logic [31:0] y0,
			input logic [31:0] h0);
		drain_steps();
		write_reg(bmes_pkg::CFG_WHEELBASE, {8'd0, wb});
		write_reg(bmes_pkg::CFG_SPEED, {8'd0, spd});
		write_reg(bmes_pkg::CFG_SAMPLE_TIME, {8'd0, ts});
		write_reg(bmes_pkg::CFG_INITIAL_X, x0);
		write_reg(bmes_pkg::CFG_INITIAL_Y, y0);
		write_reg(bmes_pkg::CFG_INITIAL_HEADING, h0);
		send_item(1'b1, $urandom);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset setting, steering extremes and clamp edges.
		send_item(1'b0, 32'sd0);
		set_setting(24'd65536, 24'd200000, 24'd1677722, 32'd0, 32'd0, 32'd0);
		send_item(1'b0, 32'h7FFF_FFFF);
		send_item(1'b0, 32'h8000_0000);
		send_item(1'b0, bmes_pkg::STEER_LIM);
		send_item(1'b0, bmes_pkg::STEER_LIM - 32'sd1);
		send_item(1'b0, -bmes_pkg::STEER_LIM);
		send_item(1'b0, -bmes_pkg::STEER_LIM + 32'sd1);
		send_item(1'b0, 32'hFFFF_FFFF);
		send_item(1'b0, 32'sd1);
		send_item(1'b1, 32'sd0);
		send_item(1'b0, 32'sd0);
		// Zero wheelbase gives nothing; tiny wheelbase saturates heading.
		set_setting(24'd0, 24'h7FFFFF, 24'hFFFFFF, 32'h7FFF_0000, 32'h8000_0000, 32'd0);
		send_item(1'b0, 32'sd100000);
		send_item(1'b0, -32'sd100000);
		set_setting(24'd1, 24'h7FFFFF, 24'hFFFFFF, 32'h7FFF_0000, 32'h8000_0000,
			32'h7FFF_FFFF);
		for (int i = 0; i < 4; i++) send_item(1'b0, bmes_pkg::STEER_LIM);
		set_setting(24'hFFFFFF, 24'h800000, 24'd1, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000);
		send_item(1'b0, -bmes_pkg::STEER_LIM);
		send_item(1'b0, 32'sd0);

		// Random: each phase four new settings, each with one pause for a full drain.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 70 : 0;
			recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 17 : 0;
			for (int k = 0; k < 4; k++) begin
				set_setting(($urandom_range(9) == 0) ? 24'd0 :
						24'($urandom_range(1) ? $urandom : $urandom_range(262144, 16384)),
					24'($urandom),
					24'($urandom_range(1) ? $urandom_range(100000, 1) : $urandom),
					$urandom, $urandom, $urandom);
				for (int n = 0; n < 58; n++) begin
					send_item($urandom_range(19) == 0, rand_steer());
					if (n == 20) wait_results();
				end
			end
		end
		drain_steps();
		$display("Sent %0d items over 16 register settings; %0d results checked, %0d saturated.",
			items_sent, results_seen, saturations_seen);
		if (fail_count == 0) begin
			$display("** bicycle_model_euler_step_core: PASSED **");
		end else begin
			$display("** bicycle_model_euler_step_core: FAILED **");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("** bicycle_model_euler_step_core: FAILED **");
		$finish;
	end

endmodule

### sim.f
src/bmes_pkg.sv
src/bmes_ctrl.sv
src/bmes_datapath.sv
src/bicycle_model_euler_step_core.sv
sim/bmes_checker.sv
sim/testbench.sv
